@@ hdl/cpc_pkg.sv @@
`default_nettype none

package cpc_pkg;

	localparam int FRAME_LEN = 8;
	localparam int FRAME_IDX_W = $clog2(FRAME_LEN);
	localparam int POS_W = 7;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam int CNT_W = 32;
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAGIC      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEQ_WINDOW = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ARMED_MASK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ESTOP_MASK = 3'd4;

	localparam int STAT_TOTAL = 0;
	localparam int STAT_VALID = 1;
	localparam int STAT_MAGIC = 2;
	localparam int STAT_CKSUM = 3;
	localparam int STAT_SEQ   = 4;
	localparam int STAT_STOP  = 5;
	localparam int STAT_N     = 6;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_LENGTH   = 3'd1,
		ST_MAGIC    = 3'd2,
		ST_CHECKSUM = 3'd3,
		ST_SEQUENCE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		EV_NONE   = 2'd0,
		EV_ARM    = 2'd1,
		EV_DISARM = 2'd2
	} arm_event_t;

	typedef struct packed {
		logic       enable;
		logic [7:0] magic_value;
		logic [7:0] sequence_window;
		logic [7:0] armed_mask;
		logic [7:0] estop_mask;
	} cfg_t;

	// one-cycle pulses on a real change of the enable register
	typedef struct packed {
		logic en_rise;
		logic en_fall;
	} en_ctl_t;

	// classified frame handed from front to back
	typedef struct packed {
		status_t     status;
		logic [7:0]  seq;
		logic [7:0]  flags;
		logic [15:0] x;
		logic [15:0] y;
	} cmd_t;

endpackage

`default_nettype wire

@@ hdl/control_packet_checker.sv @@
// Control packet checker.
// Input: datagram bytes on data_byte with last_byte marking the final byte;
// a beat is taken when push is high and full is low. One result per
// datagram appears on the result ports while empty is low and is taken
// with pop. Each result carries the frame status, the command (axes,
// stop, arm state and event) and the statistics counters after it.
// Configuration: cfg_valid/cfg_ready (always ready) with cfg_index and
// cfg_data; write only while no datagram is in flight.
// Throughput: one byte per cycle while full is low. The front end keeps
// the running XOR and the eight frame bytes; a four-entry queue hands
// classified frames to the back end, which runs the sequence window,
// arm state and counters. The frame enters the queue as its final byte
// is taken and moves to the result registers once the output is free.
// Reset: config returns to its defaults (enabled, magic 165, window 16,
// armed mask 1, stop mask 2); the block is disarmed, counters are zero.
// A stalled receiver holds the result; the queue then fills, after which
// full rises and input stops.
`default_nettype none

module control_packet_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [7:0]                        data_byte,
	input  wire logic                              last_byte,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [2:0]                             status,
	output logic signed [15:0]                     x_axis,
	output logic signed [15:0]                     y_axis,
	output logic                                   stop_now,
	output logic                                   armed_now,
	output logic [1:0]                             arm_event,
	output logic [cpc_pkg::CNT_W-1:0]              total_count,
	output logic [cpc_pkg::CNT_W-1:0]              valid_count,
	output logic [cpc_pkg::CNT_W-1:0]              magic_error_count,
	output logic [cpc_pkg::CNT_W-1:0]              checksum_error_count,
	output logic [cpc_pkg::CNT_W-1:0]              sequence_error_count,
	output logic [cpc_pkg::CNT_W-1:0]              stop_count,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [cpc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [7:0]                        cfg_data
);

	cpc_pkg::cfg_t       cfg_q;
	cpc_pkg::en_ctl_t    en_ctl;
	logic                en_change;
	logic                accept;
	logic                cmd_push;
	cpc_pkg::cmd_t       cmd_in;
	cpc_pkg::cmd_t       cmd_out;
	logic                q_full;
	logic                q_empty;
	logic                cmd_pop;
	logic                out_valid;
	cpc_pkg::status_t    status_w;
	cpc_pkg::arm_event_t event_w;

	assign cfg_ready = 1'b1;

	assign en_change = cfg_valid && (cfg_index == cpc_pkg::REG_ENABLE)
		&& (cfg_data[0] != cfg_q.enable);
	assign en_ctl.en_rise = en_change && cfg_data[0];
	assign en_ctl.en_fall = en_change && !cfg_data[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable          <= 1'b1;
			cfg_q.magic_value     <= 8'd165;
			cfg_q.sequence_window <= 8'd16;
			cfg_q.armed_mask      <= 8'd1;
			cfg_q.estop_mask      <= 8'd2;
		end else if (cfg_valid) begin
			case (cfg_index)
				cpc_pkg::REG_ENABLE:     cfg_q.enable          <= cfg_data[0];
				cpc_pkg::REG_MAGIC:      cfg_q.magic_value     <= cfg_data;
				cpc_pkg::REG_SEQ_WINDOW: cfg_q.sequence_window <= cfg_data;
				cpc_pkg::REG_ARMED_MASK: cfg_q.armed_mask      <= cfg_data;
				cpc_pkg::REG_ESTOP_MASK: cfg_q.estop_mask      <= cfg_data;
				default:                 cfg_q                 <= cfg_q;
			endcase
		end
	end

	assign full   = q_full;
	assign accept = push && !q_full;

	cpc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.en_ctl    (en_ctl),
		.accept    (accept),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.cmd_push  (cmd_push),
		.cmd       (cmd_in)
	);

	cpc_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (cmd_push),
		.wr_data (cmd_in),
		.full    (q_full),
		.empty   (q_empty),
		.rd_en   (cmd_pop),
		.rd_data (cmd_out)
	);

	cpc_back u_back (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg                  (cfg_q),
		.en_ctl               (en_ctl),
		.cmd_avail            (!q_empty),
		.cmd                  (cmd_out),
		.cmd_pop              (cmd_pop),
		.out_valid            (out_valid),
		.out_pop              (pop),
		.status               (status_w),
		.x_axis               (x_axis),
		.y_axis               (y_axis),
		.stop_now             (stop_now),
		.armed_now            (armed_now),
		.arm_event            (event_w),
		.total_count          (total_count),
		.valid_count          (valid_count),
		.magic_error_count    (magic_error_count),
		.checksum_error_count (checksum_error_count),
		.sequence_error_count (sequence_error_count),
		.stop_count           (stop_count)
	);

	assign empty     = !out_valid;
	assign status    = status_w;
	assign arm_event = event_w;

endmodule

`default_nettype wire

@@ hdl/cpc_front.sv @@
`default_nettype none

module cpc_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cpc_pkg::cfg_t    cfg,
	input  wire cpc_pkg::en_ctl_t en_ctl,
	input  wire logic             accept,
	input  wire logic [7:0]       data_byte,
	input  wire logic             last_byte,
	output logic                  cmd_push,
	output cpc_pkg::cmd_t         cmd
);

	logic [cpc_pkg::POS_W-1:0] pos_q;
	logic [cpc_pkg::POS_W-1:0] pos_inc;
	logic [7:0]                xor_q;
	logic [7:0]                frame_q [cpc_pkg::FRAME_LEN];
	logic                      take;
	logic                      in_frame;
	logic                      in_xor;

	assign take     = accept && cfg.enable;
	assign in_frame = pos_q < cpc_pkg::POS_W'(cpc_pkg::FRAME_LEN);
	assign in_xor   = pos_q < cpc_pkg::POS_W'(cpc_pkg::FRAME_LEN - 1);
	assign pos_inc  = (pos_q == cpc_pkg::POS_MAX) ? pos_q : pos_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			xor_q <= '0;
		end else if (en_ctl.en_rise || en_ctl.en_fall) begin
			pos_q <= '0;
			xor_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				pos_q <= '0;
				xor_q <= '0;
			end else begin
				pos_q <= pos_inc;
				if (in_xor)
					xor_q <= xor_q ^ data_byte;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_frame)
			frame_q[pos_q[cpc_pkg::FRAME_IDX_W-1:0]] <= data_byte;
	end

	// On the final byte of a good-length frame, byte 7 is the incoming byte
	// and the running XOR already covers bytes 0 to 6.
	always_comb begin
		cmd.seq   = frame_q[1];
		cmd.x     = {frame_q[3], frame_q[2]};
		cmd.y     = {frame_q[5], frame_q[4]};
		cmd.flags = frame_q[6];
		if (pos_inc != cpc_pkg::POS_W'(cpc_pkg::FRAME_LEN))
			cmd.status = cpc_pkg::ST_LENGTH;
		else if (frame_q[0] != cfg.magic_value)
			cmd.status = cpc_pkg::ST_MAGIC;
		else if (xor_q != data_byte)
			cmd.status = cpc_pkg::ST_CHECKSUM;
		else
			cmd.status = cpc_pkg::ST_OK;
	end

	assign cmd_push = take && last_byte;

endmodule

`default_nettype wire

@@ hdl/cpc_queue.sv @@
`default_nettype none

module cpc_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire cpc_pkg::cmd_t wr_data,
	output logic               full,
	output logic               empty,
	input  wire logic          rd_en,
	output cpc_pkg::cmd_t      rd_data
);

	cpc_pkg::cmd_t               mem_q [cpc_pkg::Q_DEPTH];
	logic [cpc_pkg::Q_PTR_W-1:0] wr_ptr_q;
	logic [cpc_pkg::Q_PTR_W-1:0] rd_ptr_q;
	logic [cpc_pkg::Q_PTR_W:0]   count_q;
	logic                        do_wr;
	logic                        do_rd;

	assign full  = count_q == (cpc_pkg::Q_PTR_W+1)'(cpc_pkg::Q_DEPTH);
	assign empty = count_q == '0;
	assign do_wr = wr_en && !full;
	assign do_rd = rd_en && !empty;

	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_rd)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({do_wr, do_rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

@@ hdl/cpc_back.sv @@
`default_nettype none

module cpc_back (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire cpc_pkg::cfg_t             cfg,
	input  wire cpc_pkg::en_ctl_t          en_ctl,
	input  wire logic                      cmd_avail,
	input  wire cpc_pkg::cmd_t             cmd,
	output logic                           cmd_pop,
	output logic                           out_valid,
	input  wire logic                      out_pop,
	output cpc_pkg::status_t               status,
	output logic signed [15:0]             x_axis,
	output logic signed [15:0]             y_axis,
	output logic                           stop_now,
	output logic                           armed_now,
	output cpc_pkg::arm_event_t            arm_event,
	output logic [cpc_pkg::CNT_W-1:0]      total_count,
	output logic [cpc_pkg::CNT_W-1:0]      valid_count,
	output logic [cpc_pkg::CNT_W-1:0]      magic_error_count,
	output logic [cpc_pkg::CNT_W-1:0]      checksum_error_count,
	output logic [cpc_pkg::CNT_W-1:0]      sequence_error_count,
	output logic [cpc_pkg::CNT_W-1:0]      stop_count
);

	logic                      out_valid_q;
	cpc_pkg::status_t          status_q;
	logic [15:0]               x_q;
	logic [15:0]               y_q;
	logic                      stop_q;
	cpc_pkg::arm_event_t       event_q;
	logic                      armed_q;
	logic [7:0]                prev_seq_q;
	logic                      started_q;
	logic [cpc_pkg::CNT_W-1:0] cnt_q [cpc_pkg::STAT_N];

	logic                      adv;
	logic [7:0]                seq_dist;
	logic                      seq_ok;
	cpc_pkg::status_t          status_nxt;
	logic                      frame_ok;
	logic                      is_stop;
	logic                      want_arm;
	logic [cpc_pkg::STAT_N-1:0] bump;

	assign adv     = cmd_avail && (!out_valid_q || out_pop);
	assign cmd_pop = adv;

	assign seq_dist = cmd.seq - prev_seq_q;
	assign seq_ok   = !started_q
		|| ((seq_dist != 8'd0) && (seq_dist <= cfg.sequence_window));

	always_comb begin
		if (cmd.status != cpc_pkg::ST_OK)
			status_nxt = cmd.status;
		else if (!seq_ok)
			status_nxt = cpc_pkg::ST_SEQUENCE;
		else
			status_nxt = cpc_pkg::ST_OK;
	end

	assign frame_ok = status_nxt == cpc_pkg::ST_OK;
	assign is_stop  = (cmd.flags & cfg.estop_mask) != 8'd0;
	assign want_arm = (cmd.flags & cfg.armed_mask) != 8'd0;

	always_comb begin
		bump                      = '0;
		bump[cpc_pkg::STAT_TOTAL] = 1'b1;
		bump[cpc_pkg::STAT_VALID] = frame_ok;
		bump[cpc_pkg::STAT_MAGIC] = status_nxt == cpc_pkg::ST_MAGIC;
		bump[cpc_pkg::STAT_CKSUM] = status_nxt == cpc_pkg::ST_CHECKSUM;
		bump[cpc_pkg::STAT_SEQ]   = status_nxt == cpc_pkg::ST_SEQUENCE;
		bump[cpc_pkg::STAT_STOP]  = frame_ok && is_stop;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			armed_q     <= 1'b0;
			prev_seq_q  <= '0;
			started_q   <= 1'b0;
			for (int i = 0; i < cpc_pkg::STAT_N; i++)
				cnt_q[i] <= '0;
		end else if (en_ctl.en_rise) begin
			started_q <= 1'b0;
			for (int i = 0; i < cpc_pkg::STAT_N; i++)
				cnt_q[i] <= '0;
		end else if (en_ctl.en_fall) begin
			armed_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
			for (int i = 0; i < cpc_pkg::STAT_N; i++)
				if (bump[i])
					cnt_q[i] <= cnt_q[i] + 1'b1;
			if (frame_ok) begin
				prev_seq_q <= cmd.seq;
				started_q  <= 1'b1;
				armed_q    <= is_stop ? 1'b0 : want_arm;
			end
		end else if (out_pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q <= status_nxt;
			x_q      <= '0;
			y_q      <= '0;
			stop_q   <= 1'b0;
			event_q  <= cpc_pkg::EV_NONE;
			if (frame_ok) begin
				if (is_stop) begin
					stop_q <= 1'b1;
				end else begin
					x_q <= cmd.x;
					y_q <= cmd.y;
					if (want_arm && !armed_q)
						event_q <= cpc_pkg::EV_ARM;
					else if (!want_arm && armed_q)
						event_q <= cpc_pkg::EV_DISARM;
				end
			end
		end
	end

	// counters and armed state move only on a result load or an enable
	// change, so otherwise they read as the snapshot of the result shown
	assign out_valid            = out_valid_q;
	assign status               = status_q;
	assign x_axis               = $signed(x_q);
	assign y_axis               = $signed(y_q);
	assign stop_now             = stop_q;
	assign armed_now            = armed_q;
	assign arm_event            = event_q;
	assign total_count          = cnt_q[cpc_pkg::STAT_TOTAL];
	assign valid_count          = cnt_q[cpc_pkg::STAT_VALID];
	assign magic_error_count    = cnt_q[cpc_pkg::STAT_MAGIC];
	assign checksum_error_count = cnt_q[cpc_pkg::STAT_CKSUM];
	assign sequence_error_count = cnt_q[cpc_pkg::STAT_SEQ];
	assign stop_count           = cnt_q[cpc_pkg::STAT_STOP];

	a_stop_disarms: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && stop_q |-> !armed_q)
		else $error("stop result with armed state set");

	a_reject_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (status_q != cpc_pkg::ST_OK) |->
			(x_q == '0) && (y_q == '0) && !stop_q && (event_q == cpc_pkg::EV_NONE))
		else $error("rejected frame carries command data");

	a_arm_event: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (event_q == cpc_pkg::EV_ARM) |-> armed_q)
		else $error("arm event without armed state");

	a_valid_bump: assert property (@(posedge clk) disable iff (!arst_n)
		adv && frame_ok && !en_ctl.en_rise && !en_ctl.en_fall |=>
			cnt_q[cpc_pkg::STAT_VALID] ==
				$past(cnt_q[cpc_pkg::STAT_VALID]) + cpc_pkg::CNT_W'(1))
		else $error("accepted frame not counted");

endmodule

`default_nettype wire
